// ===== hw/rtl/afr_pkg.sv =====
`timescale 1ns / 1ps

package afr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned LEN_W   = 16;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [BYTE_W-1:0] START_DELIM_RST   = 8'h7E;
	localparam logic [BYTE_W-1:0] SKIP_COUNT_RST    = 8'h00;
	localparam logic [LEN_W-1:0]  PAYLOAD_LIMIT_RST = 16'd128;
	localparam logic [BYTE_W-1:0] CHECK_BASE        = 8'hFF;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_DELIM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LIMIT = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT   = 3'd0,
		PH_LEN_HI = 3'd1,
		PH_LEN_LO = 3'd2,
		PH_DATA   = 3'd3,
		PH_CHECK  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_delim;
		logic [BYTE_W-1:0] skip_count;
		logic [LEN_W-1:0]  payload_limit;
	} cfg_t;

endpackage

// ===== hw/rtl/afr_channels.sv =====
`timescale 1ns / 1ps

interface afr_byte_if;
	logic                        valid;
	logic                        ready;
	logic [afr_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afr_result_if;
	logic                        valid;
	logic                        ready;
	logic [afr_pkg::KIND_W-1:0]  kind;
	logic [afr_pkg::BYTE_W-1:0]  payload_byte;

	modport source (output valid, output kind, output payload_byte, input ready);
	modport sink   (input valid, input kind, input payload_byte, output ready);
endinterface

// ===== hw/rtl/afr_deframer.sv =====
`timescale 1ns / 1ps

module afr_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  afr_pkg::cfg_t               cfg,
	input  logic                        step_valid,
	input  logic [afr_pkg::BYTE_W-1:0]  step_byte,
	output logic                        step_ready,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [afr_pkg::KIND_W-1:0]  res_kind,
	output logic [afr_pkg::BYTE_W-1:0]  res_payload
);

	afr_pkg::phase_t             phase_q, phase_n;
	logic [afr_pkg::LEN_W-1:0]   len_q, len_n;
	logic [afr_pkg::LEN_W-1:0]   read_q, read_n;
	logic [afr_pkg::LEN_W-1:0]   emitted_q, emitted_n;
	logic [afr_pkg::BYTE_W-1:0]  sum_q, sum_n;
	logic [afr_pkg::LEN_W-1:0]   read_inc;
	logic [afr_pkg::LEN_W-1:0]   len_full;

	logic                        emit_c;
	logic [afr_pkg::KIND_W-1:0]  kind_c;
	logic [afr_pkg::BYTE_W-1:0]  payload_c;

	logic                        out_valid_q;
	logic [afr_pkg::KIND_W-1:0]  out_kind_q;
	logic [afr_pkg::BYTE_W-1:0]  out_payload_q;
	logic                        fire;

	assign step_ready = !out_valid_q || res_ready;
	assign fire       = step_valid && step_ready;
	assign read_inc   = read_q + afr_pkg::LEN_W'(1);
	assign len_full   = {len_q[afr_pkg::LEN_W-1:afr_pkg::BYTE_W], step_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= afr_pkg::PH_HUNT;
			len_q     <= '0;
			read_q    <= '0;
			emitted_q <= '0;
			sum_q     <= '0;
		end else if (fire) begin
			phase_q   <= phase_n;
			len_q     <= len_n;
			read_q    <= read_n;
			emitted_q <= emitted_n;
			sum_q     <= sum_n;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		len_n     = len_q;
		read_n    = read_q;
		emitted_n = emitted_q;
		sum_n     = sum_q;
		emit_c    = 1'b0;
		kind_c    = afr_pkg::KIND_PAYLOAD;
		payload_c = '0;
		case (phase_q)
			afr_pkg::PH_LEN_HI: begin
				len_n   = {step_byte, afr_pkg::BYTE_W'(0)};
				phase_n = afr_pkg::PH_LEN_LO;
			end
			afr_pkg::PH_LEN_LO: begin
				len_n   = len_full;
				phase_n = (len_full == '0) ? afr_pkg::PH_CHECK : afr_pkg::PH_DATA;
			end
			afr_pkg::PH_DATA: begin
				read_n = read_inc;
				sum_n  = sum_q + step_byte;
				if (read_inc >= len_q)
					phase_n = afr_pkg::PH_CHECK;
				// bytes past the limit still count toward the checksum
				if (read_inc > {{(afr_pkg::LEN_W-afr_pkg::BYTE_W){1'b0}}, cfg.skip_count}
						&& emitted_q < cfg.payload_limit) begin
					emitted_n = emitted_q + afr_pkg::LEN_W'(1);
					emit_c    = 1'b1;
					payload_c = step_byte;
				end
			end
			afr_pkg::PH_CHECK: begin
				emit_c    = 1'b1;
				kind_c    = (step_byte == afr_pkg::CHECK_BASE - sum_q) ?
				            afr_pkg::KIND_GOOD : afr_pkg::KIND_BAD;
				phase_n   = afr_pkg::PH_HUNT;
				len_n     = '0;
				read_n    = '0;
				emitted_n = '0;
				sum_n     = '0;
			end
			default: begin
				phase_n = afr_pkg::PH_HUNT;
				if (step_byte == cfg.start_delim) begin
					phase_n   = afr_pkg::PH_LEN_HI;
					len_n     = '0;
					read_n    = '0;
					emitted_n = '0;
					sum_n     = '0;
				end
			end
		endcase
	end

	// result register, refilled in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step_ready)
			out_valid_q <= fire && emit_c;
	end

	always_ff @(posedge clk) begin
		if (fire && emit_c) begin
			out_kind_q    <= kind_c;
			out_payload_q <= payload_c;
		end
	end

	assign res_valid   = out_valid_q;
	assign res_kind    = out_kind_q;
	assign res_payload = out_payload_q;

`ifndef SYNTHESIS
	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == afr_pkg::PH_HUNT |-> read_q == '0 && sum_q == '0 && emitted_q == '0)
		else $error("hunting with stale frame counters");

	a_check_reached: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == afr_pkg::PH_CHECK |-> read_q >= len_q)
		else $error("checksum phase before all data bytes read");

	a_zero_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q != afr_pkg::KIND_PAYLOAD |-> out_payload_q == '0)
		else $error("frame status carries nonzero payload byte");

	a_header_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == afr_pkg::PH_LEN_HI || phase_q == afr_pkg::PH_LEN_LO)
		|=> !out_valid_q)
		else $error("length byte produced a result");
`endif

endmodule

// ===== hw/rtl/api_frame_receiver_top.sv =====
`timescale 1ns / 1ps

// channel   dir   payload                      handshake
// rx        in    rx_byte[7:0]                 valid / ready
// res       out   kind[1:0], payload_byte[7:0] valid / ready
// cfg       in    cfg_index[1:0], cfg_wr_data  cfg_wr_en, no back-pressure
//
// one byte per cycle sustained while res accepts results; res back-pressure stalls the path
// the byte sits in an input register, then one pass through the deframer fills the result reg
// rx stays ready while a result is held, as long as the input register is empty or draining
// arst_n clears the frame state, the valid flags and the config registers to their defaults
module api_frame_receiver_top (
	input  logic                            clk,
	input  logic                            arst_n,
	afr_byte_if.sink                        rx,
	afr_result_if.source                    res,
	input  logic                            cfg_wr_en,
	input  logic [afr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [afr_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

	afr_pkg::cfg_t               cfg_q;
	logic                        valid_s1;
	logic [afr_pkg::BYTE_W-1:0]  byte_s1;
	logic                        step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_delim   <= afr_pkg::START_DELIM_RST;
			cfg_q.skip_count    <= afr_pkg::SKIP_COUNT_RST;
			cfg_q.payload_limit <= afr_pkg::PAYLOAD_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				afr_pkg::CFG_START_DELIM:
					cfg_q.start_delim <= cfg_wr_data[afr_pkg::BYTE_W-1:0];
				afr_pkg::CFG_SKIP_COUNT:
					cfg_q.skip_count <= cfg_wr_data[afr_pkg::BYTE_W-1:0];
				afr_pkg::CFG_PAYLOAD_LIMIT:
					cfg_q.payload_limit <= cfg_wr_data[afr_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign rx.ready = !valid_s1 || step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx.ready)
			valid_s1 <= rx.valid;
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx.rx_byte;
	end

	afr_deframer u_deframer (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.step_valid  (valid_s1),
		.step_byte   (byte_s1),
		.step_ready  (step_ready),
		.res_valid   (res.valid),
		.res_ready   (res.ready),
		.res_kind    (res.kind),
		.res_payload (res.payload_byte)
	);

endmodule
